@@ design/lzbd_pkg.sv @@
// shared types and constants of the lz byte-token decompressor
package lzbd_pkg;

  localparam int DEFAULT_WINDOW_BYTES = 32768;

  localparam int BYTE_W = 8;
  localparam int LEN_W  = 7;   // copy length, up to 67
  localparam int DIST_W = 16;  // copy distance, up to 32768
  localparam int ACC_W  = 13;  // token bits held between bytes
  localparam int LIT_W  = 7;   // literal run counter
  localparam int CNT_W  = 2;

  // token layout
  localparam logic [BYTE_W-1:0] TOKEN_END = 8'h00;

  typedef struct packed {
    logic [BYTE_W-1:0] in_byte;
    logic              new_stream;
  } lzbd_in_t;

  typedef struct packed {
    logic [BYTE_W-1:0] first_byte;
    logic [BYTE_W-1:0] second_byte;
    logic [CNT_W-1:0]  byte_count;
    logic              last_of_run;
    logic              stream_end;
    logic              bad_distance;
  } lzbd_out_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_LIT,
    PH_MID_B1,
    PH_LONG_B1,
    PH_LONG_B2
  } lzbd_phase_t;

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_LIT,
    CMD_COPY,
    CMD_END
  } lzbd_cmd_kind_t;

  typedef struct packed {
    logic              start;   // a request was taken this cycle
    logic              clear;   // restart the produced-byte count first
    lzbd_cmd_kind_t    kind;
    logic [BYTE_W-1:0] data;
    logic [LEN_W-1:0]  len;
    logic [DIST_W-1:0] copy_dist;
  } lzbd_cmd_t;

  typedef enum logic [1:0] {
    ENG_IDLE,
    ENG_READ,
    ENG_WRITE,
    ENG_EMIT
  } lzbd_eng_state_t;

  localparam logic [CNT_W-1:0] COUNT_NONE = 2'd0;
  localparam logic [CNT_W-1:0] COUNT_ONE  = 2'd1;
  localparam logic [CNT_W-1:0] COUNT_TWO  = 2'd2;

endpackage

@@ design/lzbd_ram.sv @@
// generic single-write, single-read ram with registered read data
module lzbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/lzbd_parser.sv @@
// token parser: turns compressed bytes into literal, copy and end commands
module lzbd_parser (
  input  logic               clk,
  input  logic               rst,
  input  logic               take,
  input  lzbd_pkg::lzbd_in_t req,
  output lzbd_pkg::lzbd_cmd_t cmd
);
  import lzbd_pkg::*;

  lzbd_phase_t      phase, phase_next;
  logic [ACC_W-1:0] token_acc, token_acc_next;
  logic [LIT_W-1:0] literal_left, literal_left_next;

  lzbd_phase_t       cur_phase;
  logic [BYTE_W-1:0] b;
  logic [20:0]       long_code;
  logic [12:0]       mid_code;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      token_acc    <= '0;
      literal_left <= '0;
    end else begin
      phase        <= phase_next;
      token_acc    <= token_acc_next;
      literal_left <= literal_left_next;
    end
  end

  always_comb begin
    b         = req.in_byte;
    cur_phase = req.new_stream ? PH_IDLE : phase;
    mid_code  = {token_acc[4:0], b};
    long_code = {token_acc, b};

    phase_next        = phase;
    token_acc_next    = token_acc;
    literal_left_next = literal_left;

    cmd       = '0;
    cmd.start = take;
    cmd.clear = take & req.new_stream;
    cmd.kind  = CMD_NONE;
    cmd.data  = b;

    if (take) begin
      if (req.new_stream) begin
        token_acc_next    = '0;
        literal_left_next = '0;
      end
      case (cur_phase)
        PH_LIT: begin
          cmd.kind          = CMD_LIT;
          literal_left_next = literal_left - 1'b1;
          phase_next        = (literal_left == LIT_W'(1)) ? PH_IDLE : PH_LIT;
        end
        PH_MID_B1: begin
          cmd.kind       = CMD_COPY;
          cmd.len        = LEN_W'(mid_code[2:0]) + LEN_W'(3);
          cmd.copy_dist  = DIST_W'(mid_code[12:3]) + DIST_W'(1);
          phase_next     = PH_IDLE;
          token_acc_next = '0;
        end
        PH_LONG_B1: begin
          token_acc_next = {token_acc[4:0], b};
          phase_next     = PH_LONG_B2;
        end
        PH_LONG_B2: begin
          cmd.kind       = CMD_COPY;
          cmd.len        = LEN_W'(long_code[5:0]) + LEN_W'(4);
          cmd.copy_dist  = DIST_W'(long_code[20:6]) + DIST_W'(1);
          phase_next     = PH_IDLE;
          token_acc_next = '0;
        end
        default: begin
          phase_next = PH_IDLE;
          if (b[7]) begin
            if (b[6]) begin
              token_acc_next = ACC_W'(b);
              phase_next     = b[5] ? PH_LONG_B1 : PH_MID_B1;
            end else begin
              cmd.kind      = CMD_COPY;
              cmd.len       = LEN_W'(b[1:0]) + LEN_W'(2);
              cmd.copy_dist = DIST_W'(b[5:2]) + DIST_W'(1);
            end
          end else if (b == TOKEN_END) begin
            cmd.kind = CMD_END;
          end else begin
            literal_left_next = b[6:0];
            phase_next        = PH_LIT;
          end
        end
      endcase
    end
  end

endmodule

@@ design/lzbd_engine.sv @@
// history engine: writes literals, runs copies through one address unit, builds results
module lzbd_engine #(
  parameter int WINDOW_BYTES = lzbd_pkg::DEFAULT_WINDOW_BYTES
) (
  input  logic                clk,
  input  logic                rst,
  input  lzbd_pkg::lzbd_cmd_t cmd,
  output logic                idle,
  output logic                dec_valid,
  input  logic                dec_ready,
  output lzbd_pkg::lzbd_out_t dec_data
);
  import lzbd_pkg::*;

  localparam int AW = $clog2(WINDOW_BYTES);
  localparam int CW = $clog2(WINDOW_BYTES + 1);

  lzbd_eng_state_t   state, state_next;
  logic [AW-1:0]     wpos, wpos_next;
  logic [CW-1:0]     fill, fill_next;
  logic [LEN_W-1:0]  left, left_next;
  logic [DIST_W-1:0] copy_dist, copy_dist_next;
  logic              slot, slot_next;
  logic              bad_acc, bad_acc_next;
  logic              rd_bad, rd_bad_next;
  logic [BYTE_W-1:0] b0, b0_next;
  lzbd_out_t         res, res_next;
  logic              out_valid, out_valid_next;
  lzbd_out_t         out_data, out_data_next;

  logic              we;
  logic [BYTE_W-1:0] wdata;
  logic [AW-1:0]     raddr;
  logic [BYTE_W-1:0] rdata;
  logic [AW:0]       diff;
  logic [CW-1:0]     fill_base;
  logic [AW-1:0]     wpos_inc;
  logic [CW-1:0]     fill_inc;
  logic [BYTE_W-1:0] copy_byte;
  logic              bad_now;
  logic              emit_ok;

  lzbd_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (WINDOW_BYTES)
  ) u_hist (
    .clk   (clk),
    .we    (we),
    .waddr (wpos),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ENG_IDLE;
      wpos      <= '0;
      fill      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      wpos      <= wpos_next;
      fill      <= fill_next;
      out_valid <= out_valid_next;
    end
    left      <= left_next;
    copy_dist <= copy_dist_next;
    slot      <= slot_next;
    bad_acc   <= bad_acc_next;
    rd_bad    <= rd_bad_next;
    b0        <= b0_next;
    res       <= res_next;
    out_data  <= out_data_next;
  end

  always_comb begin
    // shared address unit: source address with wrap, distance check
    diff  = (AW + 1)'(wpos) - (AW + 1)'(copy_dist);
    raddr = diff[AW] ? AW'(diff + (AW + 1)'(WINDOW_BYTES)) : diff[AW-1:0];

    wpos_inc  = (wpos == AW'(WINDOW_BYTES - 1)) ? '0 : wpos + 1'b1;
    fill_base = (state == ENG_IDLE && cmd.clear) ? '0 : fill;
    fill_inc  = (fill_base < CW'(WINDOW_BYTES)) ? fill_base + 1'b1 : fill_base;
    copy_byte = rd_bad ? '0 : rdata;
    bad_now   = bad_acc | rd_bad;
    emit_ok   = !out_valid || dec_ready;

    state_next     = state;
    wpos_next      = wpos;
    fill_next      = fill_base;
    left_next      = left;
    copy_dist_next = copy_dist;
    slot_next      = slot;
    bad_acc_next   = bad_acc;
    rd_bad_next    = rd_bad;
    b0_next        = b0;
    res_next       = res;
    out_valid_next = out_valid && !dec_ready;
    out_data_next  = out_data;
    we             = 1'b0;
    wdata          = cmd.data;

    case (state)
      ENG_IDLE: begin
        if (cmd.start) begin
          case (cmd.kind)
            CMD_LIT: begin
              we         = 1'b1;
              wpos_next  = wpos_inc;
              fill_next  = fill_inc;
              res_next   = '{first_byte: cmd.data, second_byte: '0,
                             byte_count: COUNT_ONE, last_of_run: 1'b1,
                             stream_end: 1'b0, bad_distance: 1'b0};
              state_next = ENG_EMIT;
            end
            CMD_END: begin
              res_next   = '{first_byte: '0, second_byte: '0,
                             byte_count: COUNT_NONE, last_of_run: 1'b1,
                             stream_end: 1'b1, bad_distance: 1'b0};
              state_next = ENG_EMIT;
            end
            CMD_COPY: begin
              left_next      = cmd.len;
              copy_dist_next = cmd.copy_dist;
              slot_next      = 1'b0;
              bad_acc_next   = 1'b0;
              state_next     = ENG_READ;
            end
            default: begin
              state_next = ENG_IDLE;
            end
          endcase
        end
      end
      ENG_READ: begin
        rd_bad_next = CW'(copy_dist) > fill;
        state_next  = ENG_WRITE;
      end
      ENG_WRITE: begin
        we        = 1'b1;
        wdata     = copy_byte;
        wpos_next = wpos_inc;
        fill_next = fill_inc;
        left_next = left - 1'b1;
        if (!slot) begin
          if (left == LEN_W'(1)) begin
            res_next   = '{first_byte: copy_byte, second_byte: '0,
                           byte_count: COUNT_ONE, last_of_run: 1'b1,
                           stream_end: 1'b0, bad_distance: bad_now};
            state_next = ENG_EMIT;
          end else begin
            b0_next      = copy_byte;
            slot_next    = 1'b1;
            bad_acc_next = bad_now;
            state_next   = ENG_READ;
          end
        end else begin
          res_next   = '{first_byte: b0, second_byte: copy_byte,
                         byte_count: COUNT_TWO, last_of_run: (left == LEN_W'(1)),
                         stream_end: 1'b0, bad_distance: bad_now};
          state_next = ENG_EMIT;
        end
      end
      ENG_EMIT: begin
        if (emit_ok) begin
          out_valid_next = 1'b1;
          out_data_next  = res;
          slot_next      = 1'b0;
          bad_acc_next   = 1'b0;
          state_next     = res.last_of_run ? ENG_IDLE : ENG_READ;
        end
      end
      default: begin
        state_next = ENG_IDLE;
      end
    endcase
  end

  assign idle      = (state == ENG_IDLE);
  assign dec_valid = out_valid;
  assign dec_data  = out_data;

endmodule

@@ design/lz_byte_token_decompressor.sv @@
// top level of the lz byte-token decompressor
// The block takes one compressed byte per request on the cmp channel and
// hands out decoded bytes, one or two per result, on the dec channel.
// A literal-run header byte, the first byte of a mid or long reference and
// the first extension byte of a long reference give nothing. A literal byte
// is written to the history, then loaded into the output register. The end
// token gives a result with byte_count 0 and stream_end set. In a
// back-reference every copied byte is one read of the history ram, through
// the one shared address and distance unit, with registered read data, and
// one write, and each result is then loaded into the output register.
// cmp_ready is high only while the engine sits idle; a finished
// result waits in the output register without holding up the next request,
// and the engine stalls only when a second result is ready before the
// first one is taken. The history ram needs no clearing after reset:
// copies that reach before the first produced byte of a stream are
// flagged with bad_distance and give zeros instead of ram data.
module lz_byte_token_decompressor #(
  parameter int WINDOW_BYTES = lzbd_pkg::DEFAULT_WINDOW_BYTES
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmp_valid,
  output logic                cmp_ready,
  input  lzbd_pkg::lzbd_in_t  cmp_data,
  output logic                dec_valid,
  input  logic                dec_ready,
  output lzbd_pkg::lzbd_out_t dec_data
);
  import lzbd_pkg::*;

  lzbd_cmd_t cmd;
  logic      eng_idle;
  logic      take;

  // a request is taken only while the engine has nothing in flight
  assign cmp_ready = eng_idle;
  assign take      = cmp_valid && cmp_ready;

  // token parsing, one byte per request
  lzbd_parser u_parser (
    .clk  (clk),
    .rst  (rst),
    .take (take),
    .req  (cmp_data),
    .cmd  (cmd)
  );

  // history window, copy sequencer and output register
  lzbd_engine #(
    .WINDOW_BYTES (WINDOW_BYTES)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .idle      (eng_idle),
    .dec_valid (dec_valid),
    .dec_ready (dec_ready),
    .dec_data  (dec_data)
  );

  // end-of-stream results carry no bytes and close the run
  a_end_shape: assert property (@(posedge clk) disable iff (rst)
    dec_valid && dec_data.stream_end |->
      dec_data.byte_count == COUNT_NONE && dec_data.last_of_run)
    else $error("stream end result malformed");

  // an empty result only ever marks stream end
  a_empty_is_end: assert property (@(posedge clk) disable iff (rst)
    dec_valid && dec_data.byte_count == COUNT_NONE |-> dec_data.stream_end)
    else $error("empty result without stream end");

  // a copy or literal command keeps the engine busy next cycle
  a_busy_after_cmd: assert property (@(posedge clk) disable iff (rst)
    cmd.start && (cmd.kind == CMD_COPY || cmd.kind == CMD_LIT) |=> !cmp_ready)
    else $error("engine ready right after starting work");

endmodule
